### rtl/caseless_line_substring_match_top_macros.svh
// assertion helpers for the caseless line matcher
`ifndef CASELESS_LINE_SUBSTRING_MATCH_TOP_MACROS_SVH
`define CASELESS_LINE_SUBSTRING_MATCH_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CLSM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CLSM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CLSM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CLSM_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/clsm_pkg.sv
package clsm_pkg;

  localparam int STORE_BYTES = 32;
  localparam int PATTERN_MAX_DEFAULT = 32;
  localparam int PATTERN_W = STORE_BYTES * 8;
  localparam int LEN_W = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int COUNT_W = 32;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam logic [CFG_INDEX_W-1:0] REG_PAT_LOW      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_MID_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_MID_HIGH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_HIGH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_LENGTH   = 3'd4;

  typedef struct packed {
    logic step;   // non-newline byte accepted: cells shift
    logic clear;  // line end accepted: cells drop their partial matches
  } chain_ctrl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'd65 && b <= 8'd90) r = b + 8'd32;
    return r;
  endfunction

endpackage

### rtl/clsm_cell.sv
module clsm_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  clsm_pkg::chain_ctrl_t ctrl,
  input  logic                  en,
  input  logic [7:0]            pat_byte,
  input  logic [7:0]            text_folded,
  input  logic                  prev,
  output logic                  match,
  output logic                  match_upd
);

  logic eq;

  assign eq = (clsm_pkg::fold_case(pat_byte) == text_folded);

  // cells past the active length keep their bit
  assign match_upd = (ctrl.step && en) ? (prev && eq) : match;

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.clear) begin
      match <= 1'b0;
    end else begin
      match <= match_upd;
    end
  end

endmodule

### rtl/clsm_chain.sv
module clsm_chain #(
  parameter int PATTERN_MAX = clsm_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  clsm_pkg::chain_ctrl_t          ctrl,
  input  logic [clsm_pkg::PATTERN_W-1:0] pattern,
  input  logic [clsm_pkg::LEN_W-1:0]     pattern_length,
  input  logic [7:0]                     text_folded,
  output logic                           hit
);

  localparam int CELLS = (PATTERN_MAX < clsm_pkg::STORE_BYTES) ?
                         PATTERN_MAX : clsm_pkg::STORE_BYTES;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [clsm_pkg::LEN_W-1:0] LEN_CAP = clsm_pkg::LEN_W'(CELLS);

  logic [clsm_pkg::LEN_W-1:0] len_eff;
  logic [clsm_pkg::LEN_W-1:0] len_less;
  logic [IDX_W-1:0]           last_idx;
  logic [CELLS-1:0]           match;
  logic [CELLS-1:0]           match_upd;

  always_comb begin
    len_eff = pattern_length;
    if (len_eff == '0) len_eff = clsm_pkg::LEN_W'(1);
    if (len_eff > LEN_CAP) len_eff = LEN_CAP;
    len_less = len_eff - clsm_pkg::LEN_W'(1);
    last_idx = len_less[IDX_W-1:0];
  end

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic prev;
    logic en;

    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match[i-1];
    end

    assign en = (len_eff > clsm_pkg::LEN_W'(i));

    clsm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .en          (en),
      .pat_byte    (pattern[8*i +: 8]),
      .text_folded (text_folded),
      .prev        (prev),
      .match       (match[i]),
      .match_upd   (match_upd[i])
    );
  end

  assign hit = ctrl.step && match_upd[last_idx];

endmodule

### rtl/caseless_line_substring_match_top.sv
// Caseless line matcher: text enters one byte per request on s_tdata, with s_tlast on the
// final byte, and the configured pattern (up to 32 bytes, ASCII letters folded to lower
// case) is searched for in every line by a row of compare cells, one per pattern byte,
// each passing its partial-match bit to the next. A newline or the last byte closes a
// line and yields one result: line number and running match total on m_tdata, the line's
// match flag on m_tuser, end of text on m_tlast. A byte can be accepted on every
// clock; results go through a two-entry output buffer and s_tready drops only while both
// entries are full, and results are registered there. Pattern writes take effect for the
// next byte, even in the middle of a line.
`include "caseless_line_substring_match_top_macros.svh"

module caseless_line_substring_match_top #(
  parameter int PATTERN_MAX = clsm_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // text_byte
  input  logic                             s_tlast,   // end_of_text
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [2*clsm_pkg::COUNT_W-1:0]   m_tdata,   // match_total, line_number
  output logic                             m_tuser,   // line_matched
  output logic                             m_tlast,   // text_done
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [clsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data
);

  localparam int CW = clsm_pkg::COUNT_W;
  localparam int OUT_W = 2 * CW + 2;

  logic [clsm_pkg::PATTERN_W-1:0] pattern;
  logic [clsm_pkg::LEN_W-1:0]     pattern_length;

  logic                  acc;
  logic                  newline;
  logic                  line_end;
  logic [7:0]            text_folded;
  clsm_pkg::chain_ctrl_t ctrl;
  logic                  hit;

  logic                  line_hit;
  logic [CW-1:0]         line_counter;
  logic [CW-1:0]         match_counter;
  logic                  matched;
  logic [CW-1:0]         match_counter_next;
  logic [OUT_W-1:0]      result;
  logic                  push;
  logic                  pop;

  logic                  out_valid;
  logic [OUT_W-1:0]      out_data;
  logic                  skid_valid;
  logic [OUT_W-1:0]      skid_data;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern        <= '0;
      pattern_length <= clsm_pkg::LEN_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        clsm_pkg::REG_PAT_LOW:      pattern[0*64 +: 64] <= cfg_data;
        clsm_pkg::REG_PAT_MID_LOW:  pattern[1*64 +: 64] <= cfg_data;
        clsm_pkg::REG_PAT_MID_HIGH: pattern[2*64 +: 64] <= cfg_data;
        clsm_pkg::REG_PAT_HIGH:     pattern[3*64 +: 64] <= cfg_data;
        clsm_pkg::REG_PAT_LENGTH:   pattern_length <= cfg_data[clsm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // matching row
  assign acc         = s_tvalid && s_tready;
  assign newline     = (s_tdata == clsm_pkg::NEWLINE_BYTE);
  assign line_end    = newline || s_tlast;
  assign text_folded = clsm_pkg::fold_case(s_tdata);
  assign ctrl.step   = acc && !newline;
  assign ctrl.clear  = acc && line_end;

  clsm_chain #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_chain (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .pattern        (pattern),
    .pattern_length (pattern_length),
    .text_folded    (text_folded),
    .hit            (hit)
  );

  // line bookkeeping
  assign matched = line_hit || hit;

  always_comb begin
    match_counter_next = match_counter;
    if (matched && match_counter != '1) match_counter_next = match_counter + CW'(1);
  end

  assign result = {s_tlast, matched, match_counter_next, line_counter};
  assign push   = acc && line_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_hit      <= 1'b0;
      line_counter  <= CW'(1);
      match_counter <= '0;
    end else if (push) begin
      line_hit <= 1'b0;
      if (s_tlast) begin
        line_counter  <= CW'(1);
        match_counter <= '0;
      end else begin
        if (line_counter != '1) line_counter <= line_counter + CW'(1);
        match_counter <= match_counter_next;
      end
    end else if (acc && hit) begin
      line_hit <= 1'b1;
    end
  end

  // two-entry output buffer
  assign s_tready = !skid_valid;
  assign pop      = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_data[2*CW-1:CW], out_data[CW-1:0]};
  assign m_tuser  = out_data[2*CW];
  assign m_tlast  = out_data[2*CW+1];

  `CLSM_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid entry without output entry")
  `CLSM_ASSERT_IMP(a_line_nonzero, clk, rst, 1'b1, line_counter != '0, "line counter reached zero")
  `CLSM_ASSERT_IMP(a_matches_bounded, clk, rst, 1'b1, (match_counter < line_counter) || (line_counter == '1), "more matching lines than lines")
  `CLSM_ASSERT_NXT(a_text_restart, clk, rst, push && s_tlast, (line_counter == CW'(1)) && (match_counter == '0) && !line_hit, "counters not cleared after end of text")

endmodule
